// ===== hdl/cisd_pkg.sv =====
// ----------------------------------------------------------------------------
// cisd_pkg: shared types and constants
// Types and constants for the compact integer stream decoder: payload
// structs, the decoder state struct and the byte codes and counts.
// ----------------------------------------------------------------------------
package cisd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned IndexWidth = 3;

   localparam logic [ByteWidth-1:0] PrefixShort = 8'h80;
   localparam logic [ByteWidth-1:0] PrefixLong  = 8'h81;

   localparam logic FormatEscape = 1'b0;
   localparam logic FormatVarint = 1'b1;

   localparam logic [IndexWidth-1:0] IndexIdle = 3'd0;
   localparam logic [IndexWidth-1:0] IndexLast = 3'd4;

   localparam logic [CountWidth-1:0] CountOne   = 3'd1;
   localparam logic [CountWidth-1:0] CountShort = 3'd3;
   localparam logic [CountWidth-1:0] CountFour  = 3'd4;
   localparam logic [CountWidth-1:0] CountLong  = 3'd5;

   typedef struct packed {
      logic [ByteWidth-1:0] in_byte;
      logic                 format_sel;
   } req_word_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic [CountWidth-1:0]        byte_count;
      logic                         format_used;
   } rsp_word_type;

   typedef struct packed {
      logic [IndexWidth-1:0] byte_index;
      logic [ValueWidth-1:0] accumulator;
      logic                  latched_format;
      logic                  wide_prefix;
   } dec_state_type;

endpackage

// ===== hdl/cisd_if.sv =====
// ----------------------------------------------------------------------------
// cisd_req_if / cisd_rsp_if: valid-ready channels
// Byte stream channel into the decoder and decoded value channel out.
// ----------------------------------------------------------------------------
interface cisd_req_if;
   logic                              valid;
   logic                              ready;
   logic [cisd_pkg::ByteWidth-1:0]    in_byte;
   logic                              format_sel;

   modport source (output valid, output in_byte, output format_sel, input ready);
   modport sink   (input valid, input in_byte, input format_sel, output ready);
endinterface

interface cisd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cisd_pkg::ValueWidth-1:0] value;
   logic [cisd_pkg::CountWidth-1:0]       byte_count;
   logic                                  format_used;

   modport source (output valid, output value, output byte_count, output format_used,
                   input ready);
   modport sink   (input valid, input value, input byte_count, input format_used,
                   output ready);
endinterface

// ===== hdl/compact_int_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// compact_int_stream_decoder_core: compact integer stream decoder
// Decodes escape-prefixed and seven-bit varint integers from a byte stream.
// ----------------------------------------------------------------------------
// One byte word enters per cycle unless the input side stalls. Each byte is
// captured in an input register and decoded against the held state in the
// next cycle. A completed value lands in the output register when the decode
// advances; rsp_ch.valid comes from that register, which follows the input
// register. Sustained rate is one byte per cycle while the sink keeps up.
// While the output register holds a word that the sink does not take, the
// byte in the input register waits whether or not it completes a value, and
// the input side stalls once that register is full.
module compact_int_stream_decoder_core (
   input  logic             clock,
   input  logic             reset,
   cisd_req_if.sink         req_ch,
   cisd_rsp_if.source       rsp_ch
);

   logic                    in_valid_ff;
   cisd_pkg::req_word_type  in_word_ff;
   logic                    out_valid_ff;
   cisd_pkg::rsp_word_type  out_word_ff;
   cisd_pkg::dec_state_type state_ff;

   cisd_pkg::dec_state_type state_in;
   cisd_pkg::rsp_word_type  result;
   logic                    emit;
   logic                    advance;
   logic                    req_take;

   cisd_decode u_decode (
      .word      (in_word_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .emit      (emit),
      .result    (result)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.value       = out_word_ff.value;
   assign rsp_ch.byte_count  = out_word_ff.byte_count;
   assign rsp_ch.format_used = out_word_ff.format_used;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= emit;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload: hold until taken
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.in_byte    <= req_ch.in_byte;
         in_word_ff.format_sel <= req_ch.format_sel;
      end
      if (advance && emit) begin
         out_word_ff <= result;
      end
   end

endmodule

// ===== hdl/cisd_decode.sv =====
// ----------------------------------------------------------------------------
// cisd_decode: per-byte decode step
// Combines one stream byte with the current decoder state; produces the
// next state and, when a value completes, the decoded word.
// ----------------------------------------------------------------------------
module cisd_decode (
   input  cisd_pkg::req_word_type  word,
   input  cisd_pkg::dec_state_type state_cur,
   output cisd_pkg::dec_state_type state_nxt,
   output logic                    emit,
   output cisd_pkg::rsp_word_type  result
);

   logic [cisd_pkg::ByteWidth-1:0]  b;
   logic [cisd_pkg::IndexWidth-1:0] k;
   logic                            first;
   logic [cisd_pkg::ValueWidth-1:0] acc_byte;
   logic [cisd_pkg::ValueWidth-1:0] acc_group;
   logic [cisd_pkg::ValueWidth-1:0] v4;

   assign b = word.in_byte;
   assign k = state_cur.byte_index;

   always_comb begin
      case (k)
         3'd1:    acc_byte = state_cur.accumulator | {24'd0, b};
         3'd2:    acc_byte = state_cur.accumulator | {16'd0, b, 8'd0};
         3'd3:    acc_byte = state_cur.accumulator | {8'd0, b, 16'd0};
         default: acc_byte = state_cur.accumulator | {b, 24'd0};
      endcase
      case (k)
         3'd1:    acc_group = state_cur.accumulator | {18'd0, b[6:0], 7'd0};
         default: acc_group = state_cur.accumulator | {11'd0, b[6:0], 14'd0};
      endcase
      v4 = state_cur.accumulator | {3'd0, b, 21'd0};
   end

   always_comb begin
      first     = (k == cisd_pkg::IndexIdle) || (k > cisd_pkg::IndexLast);
      state_nxt = state_cur;
      emit      = 1'b0;
      result    = '0;

      if (!first && state_cur.latched_format == cisd_pkg::FormatEscape) begin
         state_nxt.accumulator = acc_byte;
         if (!state_cur.wide_prefix && k == 3'd2) begin
            emit               = 1'b1;
            result.value       = {{16{acc_byte[15]}}, acc_byte[15:0]};
            result.byte_count  = cisd_pkg::CountShort;
            result.format_used = cisd_pkg::FormatEscape;
         end else if (state_cur.wide_prefix && k == cisd_pkg::IndexLast) begin
            emit               = 1'b1;
            result.value       = acc_byte;
            result.byte_count  = cisd_pkg::CountLong;
            result.format_used = cisd_pkg::FormatEscape;
         end else if (!state_cur.wide_prefix && k > 3'd2) begin
            first = 1'b1;
         end else begin
            state_nxt.byte_index = k + 3'd1;
         end
      end else if (!first) begin
         if (k == 3'd1 || k == 3'd2) begin
            state_nxt.accumulator = acc_group;
            if (b[7]) begin
               state_nxt.byte_index = k + 3'd1;
            end else begin
               emit               = 1'b1;
               result.value       = acc_group;
               result.byte_count  = k + 3'd1;
               result.format_used = cisd_pkg::FormatVarint;
            end
         end else if (k == 3'd3) begin
            emit               = 1'b1;
            result.value       = {{4{v4[28]}}, v4[27:0]};
            result.byte_count  = cisd_pkg::CountFour;
            result.format_used = cisd_pkg::FormatVarint;
         end else begin
            first = 1'b1;
         end
      end

      if (first) begin
         state_nxt                = state_cur;
         state_nxt.latched_format = word.format_sel;
         state_nxt.accumulator    = '0;
         if (word.format_sel == cisd_pkg::FormatEscape) begin
            if (b == cisd_pkg::PrefixShort || b == cisd_pkg::PrefixLong) begin
               state_nxt.wide_prefix = b[0];
               state_nxt.byte_index  = 3'd1;
            end else begin
               emit               = 1'b1;
               result.value       = {{24{b[7]}}, b};
               result.byte_count  = cisd_pkg::CountOne;
               result.format_used = cisd_pkg::FormatEscape;
            end
         end else if (b[7]) begin
            state_nxt.accumulator = {25'd0, b[6:0]};
            state_nxt.byte_index  = 3'd1;
         end else begin
            emit               = 1'b1;
            result.value       = {24'd0, b};
            result.byte_count  = cisd_pkg::CountOne;
            result.format_used = cisd_pkg::FormatVarint;
         end
      end

      if (emit) begin
         state_nxt.byte_index  = cisd_pkg::IndexIdle;
         state_nxt.accumulator = '0;
      end
   end

endmodule

// ===== bench/tb_compact_int_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_compact_int_stream_decoder_core: decoder self-checking bench
// Feeds byte words into the decoder and checks each decoded value word against
// the table or an in-bench decoder. A fixed table covers the field extremes,
// both formats and every byte length. Random values follow, mostly well-formed
// and partly raw noise, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_compact_int_stream_decoder_core;
   import cisd_pkg::*;

   typedef struct packed {
      logic [ByteWidth-1:0]  in_byte;
      logic                  format_sel;
      logic                  has_value;
      logic [ValueWidth-1:0] value;
      logic [CountWidth-1:0] byte_count;
      logic                  format_used;
   } stim_row_type;

   localparam int NumRows     = 25;
   localparam int RandomBytes = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cisd_req_if req_ch ();
   cisd_rsp_if rsp_ch ();

   compact_int_stream_decoder_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   dec_state_type pred_state = '0;
   rsp_word_type  pending_values [$];
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   stall_left = 0;
   bit            req_calm = 1'b0;

   stim_row_type dir_rows [0:NumRows-1] = '{
      '{8'h00, FormatEscape, 1'b1, 32'h0000_0000, CountOne,   FormatEscape},
      '{8'h7f, FormatEscape, 1'b1, 32'h0000_007f, CountOne,   FormatEscape},
      '{8'hff, FormatEscape, 1'b1, 32'hffff_ffff, CountOne,   FormatEscape},
      '{8'h7f, FormatVarint, 1'b1, 32'h0000_007f, CountOne,   FormatVarint},
      '{8'h80, FormatEscape, 1'b0, '0,            '0,         FormatEscape},
      '{8'h00, FormatVarint, 1'b0, '0,            '0,         FormatEscape},
      '{8'h80, FormatVarint, 1'b1, 32'hffff_8000, CountShort, FormatEscape},
      '{8'h81, FormatEscape, 1'b0, '0,            '0,         FormatEscape},
      '{8'hff, FormatVarint, 1'b0, '0,            '0,         FormatEscape},
      '{8'hff, FormatEscape, 1'b0, '0,            '0,         FormatEscape},
      '{8'hff, FormatVarint, 1'b0, '0,            '0,         FormatEscape},
      '{8'h7f, FormatEscape, 1'b1, 32'h7fff_ffff, CountLong,  FormatEscape},
      '{8'h80, FormatVarint, 1'b0, '0,            '0,         FormatEscape},
      '{8'h80, FormatEscape, 1'b0, '0,            '0,         FormatEscape},
      '{8'h80, FormatVarint, 1'b0, '0,            '0,         FormatEscape},
      '{8'h80, FormatEscape, 1'b1, 32'hf000_0000, CountFour,  FormatVarint},
      '{8'hff, FormatVarint, 1'b0, '0,            '0,         FormatEscape},
      '{8'hff, FormatEscape, 1'b0, '0,            '0,         FormatEscape},
      '{8'hff, FormatVarint, 1'b0, '0,            '0,         FormatEscape},
      '{8'hff, FormatVarint, 1'b1, 32'hffff_ffff, CountFour,  FormatVarint},
      '{8'h85, FormatVarint, 1'b0, '0,            '0,         FormatEscape},
      '{8'h03, FormatEscape, 1'b0, '0,            '0,         FormatEscape},
      '{8'h82, FormatEscape, 1'b1, 32'hffff_ff82, CountOne,   FormatEscape},
      '{8'h80, FormatEscape, 1'b0, '0,            '0,         FormatEscape},
      '{8'h34, FormatVarint, 1'b0, '0,            '0,         FormatEscape}
   };

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic rsp_word_type finish_value(input logic [ValueWidth-1:0] v,
                                                 input logic [CountWidth-1:0] count,
                                                 input logic fmt);
      rsp_word_type w;
      w.value       = v;
      w.byte_count  = count;
      w.format_used = fmt;
      pred_state.byte_index  = IndexIdle;
      pred_state.accumulator = '0;
      return w;
   endfunction

   task automatic start_value(input logic [ByteWidth-1:0] b, input logic fmt,
                              output bit done, output rsp_word_type w);
      pred_state.latched_format = fmt;
      pred_state.accumulator    = '0;
      done = 1'b0;
      w    = '0;
      if (fmt == FormatEscape) begin
         if (b == PrefixShort || b == PrefixLong) begin
            pred_state.wide_prefix = b[0];
            pred_state.byte_index  = 3'd1;
         end else begin
            done = 1'b1;
            w    = finish_value({{24{b[7]}}, b}, CountOne, FormatEscape);
         end
      end else if (b[7]) begin
         pred_state.accumulator = 32'(b[6:0]);
         pred_state.byte_index  = 3'd1;
      end else begin
         done = 1'b1;
         w    = finish_value(32'(b), CountOne, FormatVarint);
      end
   endtask

   task automatic decode_byte(input logic [ByteWidth-1:0] b, input logic fmt,
                              output bit done, output rsp_word_type w);
      logic [IndexWidth-1:0] k;
      logic [ValueWidth-1:0] v;
      logic                  wide;
      k    = pred_state.byte_index;
      wide = pred_state.wide_prefix;
      done = 1'b0;
      w    = '0;
      if (k == IndexIdle || k > IndexLast) begin
         start_value(b, fmt, done, w);
      end else if (pred_state.latched_format == FormatEscape) begin
         pred_state.accumulator |= 32'(b) << (8 * (k - 1));
         v = pred_state.accumulator;
         if (!wide && k == 3'd2) begin
            done = 1'b1;
            w    = finish_value({{16{v[15]}}, v[15:0]}, CountShort, FormatEscape);
         end else if (wide && k == IndexLast) begin
            done = 1'b1;
            w    = finish_value(v, CountLong, FormatEscape);
         end else if (!wide && k > 3'd2) begin
            start_value(b, fmt, done, w);
         end else begin
            pred_state.byte_index = k + 3'd1;
         end
      end else if (k == 3'd1 || k == 3'd2) begin
         pred_state.accumulator |= 32'(b[6:0]) << (7 * k);
         if (b[7]) begin
            pred_state.byte_index = k + 3'd1;
         end else begin
            done = 1'b1;
            w    = finish_value(pred_state.accumulator, CountWidth'(k + 3'd1), FormatVarint);
         end
      end else if (k == 3'd3) begin
         v = pred_state.accumulator | (32'(b) << 21);
         if (v[28]) v |= 32'hf000_0000;
         done = 1'b1;
         w    = finish_value(v, CountFour, FormatVarint);
      end else begin
         start_value(b, fmt, done, w);
      end
   endtask

   task automatic send_word(input logic [ByteWidth-1:0] b, input logic fmt);
      int unsigned gap;
      gap = pick_gap(req_calm);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.in_byte    <= b;
      req_ch.format_sel <= fmt;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic put_byte(input logic [ByteWidth-1:0] b, input logic fmt);
      bit           done;
      rsp_word_type w;
      send_word(b, fmt);
      decode_byte(b, fmt, done, w);
      if (done) pending_values.push_back(w);
   endtask

   task automatic drain_values();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_values.size() != 0);
   endtask

   // one value: mostly well-formed, sometimes raw noise
   task automatic send_random_value(inout int unsigned sent);
      logic [ByteWidth-1:0] b;
      logic                 fmt;
      int unsigned          n;
      int unsigned          kind;
      fmt = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 12) begin
         n = $urandom_range(1, 3);
         repeat (n) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (fmt == FormatEscape) begin
         kind = $urandom_range(0, 2);
         if (kind == 0) begin
            n = 1;
            b = 8'($urandom_range(0, 255));
            if (b == PrefixShort || b == PrefixLong) b[1] = 1'b1;
            put_byte(b, fmt);
         end else begin
            n = (kind == 1) ? 3 : 5;
            put_byte((kind == 1) ? PrefixShort : PrefixLong, fmt);
            repeat (n - 1) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end else begin
         n = $urandom_range(1, 4);
         for (int i = 1; i <= n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i < 4) b[7] = (i < n);
            put_byte(b, (i == 1) ? fmt : 1'($urandom_range(0, 1)));
         end
      end
      sent += n;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_values.size() == 0) begin
               report_mismatch($sformatf("unexpected value %h", rsp_ch.value));
            end else begin
               if (rsp_ch.value !== pending_values[0].value)
                  report_mismatch($sformatf("value %h, want %h",
                                            rsp_ch.value, pending_values[0].value));
               if (rsp_ch.byte_count !== pending_values[0].byte_count)
                  report_mismatch($sformatf("byte_count %0d, want %0d",
                                            rsp_ch.byte_count, pending_values[0].byte_count));
               if (rsp_ch.format_used !== pending_values[0].format_used)
                  report_mismatch($sformatf("format_used %b, want %b",
                                            rsp_ch.format_used, pending_values[0].format_used));
               void'(pending_values.pop_front());
            end
         end
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (cycle_count[8:7] != 2'd0 && $urandom_range(0, 5) == 0)
               stall_left <= pick_gap(1'b0);
         end
      end
   end

   initial begin
      bit           done;
      bit           drained;
      int unsigned  sent;
      rsp_word_type w;
      req_ch.valid      <= 1'b0;
      req_ch.in_byte    <= '0;
      req_ch.format_sel <= FormatEscape;
      sent    = 0;
      drained = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NumRows; i++) begin
         send_word(dir_rows[i].in_byte, dir_rows[i].format_sel);
         decode_byte(dir_rows[i].in_byte, dir_rows[i].format_sel, done, w);
         if (dir_rows[i].has_value)
            pending_values.push_back(rsp_word_type'{value:       dir_rows[i].value,
                                                    byte_count:  dir_rows[i].byte_count,
                                                    format_used: dir_rows[i].format_used});
         else if (done)
            pending_values.push_back(w);
      end

      while (sent < RandomBytes) begin
         req_calm = ((sent / 50) % 4) == 1;
         if (!drained && sent >= RandomBytes / 2) begin
            drain_values();
            drained = 1'b1;
         end
         send_random_value(sent);
      end

      drain_values();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_values.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
